// ===== rtl/core/pgm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgm_pkg
// shared codes and byte constants of the path glob matcher
// ----------------------------------------------------------------------------
package pgm_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [1:0] verdict_type;
   typedef logic [1:0] op_type;

   // commands
   localparam op_type OP_PATTERN = 2'd0;
   localparam op_type OP_NAME    = 2'd1;
   localparam op_type OP_RUN     = 2'd2;

   // verdicts
   localparam verdict_type V_NOMATCH  = 2'd0;
   localparam verdict_type V_MATCH    = 2'd1;
   localparam verdict_type V_BAD      = 2'd2;
   localparam verdict_type V_OVERFLOW = 2'd3;

   // glob syntax bytes
   localparam byte_type CH_STAR   = 8'h2A;
   localparam byte_type CH_QUEST  = 8'h3F;
   localparam byte_type CH_LBRACK = 8'h5B;
   localparam byte_type CH_RBRACK = 8'h5D;
   localparam byte_type CH_BSLASH = 8'h5C;
   localparam byte_type CH_CARET  = 8'h5E;
   localparam byte_type CH_DASH   = 8'h2D;
   localparam byte_type CH_SLASH  = 8'h2F;

endpackage

// ===== rtl/core/pgm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pgm_ram
// single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module pgm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

// ===== rtl/core/path_glob_matcher_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// path_glob_matcher_unit
// path-style glob matcher: loads a pattern and a name, answers one verdict
// ----------------------------------------------------------------------------
// A beat is accepted when start is high and busy is low. Pattern and name
// bytes load one per cycle while busy is low and never raise busy. A run
// beat raises busy while a small sequencer walks both rams; every ram read
// has an address phase, then a registered data phase, and with a leading
// star the chunk is retried at each later name position. A run with an
// overflow flag pending answers on the next cycle. The verdict is shown for
// exactly one cycle with rsp_valid high; the receiver cannot stall it, so it
// must take it in that cycle. Both stores are empty again after each run.
// ----------------------------------------------------------------------------
module path_glob_matcher_unit
   import pgm_pkg::*;
#(
   parameter int PATTERN_DEPTH = 64,
   parameter int NAME_DEPTH    = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_op,
   input  wire logic [7:0]  req_symbol,
   output logic             rsp_valid,
   output logic [1:0]       rsp_verdict
);

   localparam int PAW = $clog2(PATTERN_DEPTH);
   localparam int PCW = $clog2(PATTERN_DEPTH + 1);
   localparam int NAW = $clog2(NAME_DEPTH);
   localparam int NCW = $clog2(NAME_DEPTH + 1);

   // sequencer states
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_MAIN    = 4'd1;   // next chunk or final verdict
   localparam logic [3:0] S_NC_STAR = 4'd2;   // skip leading stars
   localparam logic [3:0] S_NC_BODY = 4'd3;   // find chunk end
   localparam logic [3:0] S_AFTER   = 4'd4;   // chunk split done
   localparam logic [3:0] S_SLASH   = 4'd5;   // trailing star: scan for slash
   localparam logic [3:0] S_CM      = 4'd6;   // chunk match loop head
   localparam logic [3:0] S_CM_ESC  = 4'd7;   // escaped literal
   localparam logic [3:0] S_CL_NEG  = 4'd8;   // class caret check
   localparam logic [3:0] S_CL_BND  = 4'd9;   // class bound or close
   localparam logic [3:0] S_CL_ESC  = 4'd10;  // escaped class bound
   localparam logic [3:0] S_CL_DASH = 4'd11;  // range dash check
   localparam logic [3:0] S_RESULT  = 4'd12;  // chunk match outcome
   localparam logic [3:0] S_RETRY   = 4'd13;  // star retry at later position

   // walk modes
   localparam logic [1:0] M_MAIN  = 2'd0;
   localparam logic [1:0] M_RETRY = 2'd1;
   localparam logic [1:0] M_DRAIN = 2'd2;   // mismatch seen, syntax check only

   logic [3:0]     state_ff, state_in;
   logic [1:0]     mode_ff, mode_in;
   logic           ph_ff, ph_in;            // 0 address phase, 1 data phase
   logic [PCW-1:0] pc_ff, pc_in;
   logic [NCW-1:0] nc_ff, nc_in;
   logic           ovf_ff, ovf_in;
   logic [PCW-1:0] pp_ff, pp_in;
   logic [PCW-1:0] q_ff, q_in;
   logic [PCW-1:0] cs_ff, cs_in;
   logic [PCW-1:0] ce_ff, ce_in;
   logic [PCW-1:0] i_ff, i_in;
   logic [NCW-1:0] np_ff, np_in;
   logic [NCW-1:0] sp_ff, sp_in;
   logic [NCW-1:0] n_ff, n_in;
   logic           star_ff, star_in;
   logic           incls_ff, incls_in;
   logic           failed_ff, failed_in;
   logic           neg_ff, neg_in;
   logic           hit_ff, hit_in;
   logic           have_ff, have_in;
   logic           hiph_ff, hiph_in;
   byte_type       rv_ff, rv_in;
   byte_type       lo_ff, lo_in;
   logic           rsp_valid_ff, rsp_valid_in;
   verdict_type    rsp_verdict_ff, rsp_verdict_in;

   logic           fin;
   verdict_type    fin_verdict;
   logic           bound_done;
   byte_type       bound;

   logic           accept;
   logic           pat_we, name_we;
   logic [PAW-1:0] pat_raddr;
   logic [NAW-1:0] name_raddr;
   byte_type       pdata, ndata;

   assign busy        = (state_ff != S_IDLE);
   assign accept      = start && !busy;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = rsp_verdict_ff;

   // load writes at the fill count; full stores drop the byte
   assign pat_we  = accept && (req_op == OP_PATTERN) && (pc_ff != PCW'(PATTERN_DEPTH));
   assign name_we = accept && (req_op == OP_NAME) && (nc_ff != NCW'(NAME_DEPTH));

   // chunk split reads at q, chunk match at i; name at sp or n
   assign pat_raddr  = (state_ff == S_NC_STAR || state_ff == S_NC_BODY) ?
                       q_ff[PAW-1:0] : i_ff[PAW-1:0];
   assign name_raddr = (state_ff == S_CM || state_ff == S_CM_ESC) ?
                       sp_ff[NAW-1:0] : n_ff[NAW-1:0];

   pgm_ram #(.WIDTH(8), .DEPTH(PATTERN_DEPTH)) u_pat_ram (
      .clock   (clock),
      .wr_en   (pat_we),
      .wr_addr (pc_ff[PAW-1:0]),
      .wr_data (req_symbol),
      .rd_addr (pat_raddr),
      .rd_data (pdata)
   );

   pgm_ram #(.WIDTH(8), .DEPTH(NAME_DEPTH)) u_name_ram (
      .clock   (clock),
      .wr_en   (name_we),
      .wr_addr (nc_ff[NAW-1:0]),
      .wr_data (req_symbol),
      .rd_addr (name_raddr),
      .rd_data (ndata)
   );

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      ph_in          = ph_ff;
      pc_in          = pc_ff;
      nc_in          = nc_ff;
      ovf_in         = ovf_ff;
      pp_in          = pp_ff;
      q_in           = q_ff;
      cs_in          = cs_ff;
      ce_in          = ce_ff;
      i_in           = i_ff;
      np_in          = np_ff;
      sp_in          = sp_ff;
      n_in           = n_ff;
      star_in        = star_ff;
      incls_in       = incls_ff;
      failed_in      = failed_ff;
      neg_in         = neg_ff;
      hit_in         = hit_ff;
      have_in        = have_ff;
      hiph_in        = hiph_ff;
      rv_in          = rv_ff;
      lo_in          = lo_ff;
      rsp_valid_in   = 1'b0;
      rsp_verdict_in = rsp_verdict_ff;
      fin            = 1'b0;
      fin_verdict    = V_NOMATCH;
      bound_done     = 1'b0;
      bound          = pdata;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_PATTERN: begin
                     if (pat_we) pc_in = pc_ff + PCW'(1);
                     else        ovf_in = 1'b1;
                  end
                  OP_NAME: begin
                     if (name_we) nc_in = nc_ff + NCW'(1);
                     else         ovf_in = 1'b1;
                  end
                  OP_RUN: begin
                     if (ovf_ff) begin
                        fin         = 1'b1;
                        fin_verdict = V_OVERFLOW;
                     end else begin
                        pp_in    = '0;
                        np_in    = '0;
                        mode_in  = M_MAIN;
                        ph_in    = 1'b0;
                        state_in = S_MAIN;
                     end
                  end
                  default: ;
               endcase
            end
         end

         S_MAIN: begin
            if (pp_ff >= pc_ff) begin
               fin = 1'b1;
               fin_verdict = (mode_ff == M_DRAIN || np_ff != nc_ff) ? V_NOMATCH : V_MATCH;
            end else begin
               q_in     = pp_ff;
               star_in  = 1'b0;
               state_in = S_NC_STAR;
            end
         end

         S_NC_STAR: begin
            if (!ph_ff) begin
               if (q_ff >= pc_ff) begin
                  cs_in    = q_ff;
                  incls_in = 1'b0;
                  state_in = S_NC_BODY;
               end else begin
                  ph_in = 1'b1;
               end
            end else begin
               ph_in = 1'b0;
               if (pdata == CH_STAR) begin
                  q_in    = q_ff + PCW'(1);
                  star_in = 1'b1;
               end else begin
                  cs_in    = q_ff;
                  incls_in = 1'b0;
                  state_in = S_NC_BODY;
               end
            end
         end

         S_NC_BODY: begin
            if (!ph_ff) begin
               if (q_ff >= pc_ff) begin
                  ce_in    = q_ff;
                  state_in = S_AFTER;
               end else begin
                  ph_in = 1'b1;
               end
            end else begin
               ph_in = 1'b0;
               case (pdata)
                  CH_BSLASH: begin
                     if (({1'b0, q_ff} + (PCW + 1)'(1)) < {1'b0, pc_ff})
                        q_in = q_ff + PCW'(2);
                     else
                        q_in = q_ff + PCW'(1);
                  end
                  CH_LBRACK: begin
                     incls_in = 1'b1;
                     q_in     = q_ff + PCW'(1);
                  end
                  CH_RBRACK: begin
                     incls_in = 1'b0;
                     q_in     = q_ff + PCW'(1);
                  end
                  CH_STAR: begin
                     if (incls_ff) begin
                        q_in = q_ff + PCW'(1);
                     end else begin
                        ce_in    = q_ff;
                        state_in = S_AFTER;
                     end
                  end
                  default: q_in = q_ff + PCW'(1);
               endcase
            end
         end

         S_AFTER: begin
            if (mode_ff == M_DRAIN) begin
               i_in      = cs_ff;
               sp_in     = nc_ff;
               failed_in = 1'b0;
               state_in  = S_CM;
            end else if (star_ff && ce_ff == cs_ff) begin
               n_in     = np_ff;
               state_in = S_SLASH;
            end else begin
               i_in      = cs_ff;
               sp_in     = np_ff;
               failed_in = 1'b0;
               state_in  = S_CM;
            end
         end

         S_SLASH: begin
            if (!ph_ff) begin
               if (n_ff >= nc_ff) begin
                  fin         = 1'b1;
                  fin_verdict = V_MATCH;
               end else begin
                  ph_in = 1'b1;
               end
            end else begin
               ph_in = 1'b0;
               if (ndata == CH_SLASH) begin
                  fin         = 1'b1;
                  fin_verdict = V_NOMATCH;
               end else begin
                  n_in = n_ff + NCW'(1);
               end
            end
         end

         S_CM: begin
            if (!ph_ff) begin
               if (i_ff >= ce_ff) begin
                  state_in = S_RESULT;
               end else begin
                  failed_in = failed_ff || (sp_ff >= nc_ff);
                  ph_in     = 1'b1;
               end
            end else begin
               ph_in = 1'b0;
               case (pdata)
                  CH_LBRACK: begin
                     if (!failed_ff) begin
                        rv_in = ndata;
                        sp_in = sp_ff + NCW'(1);
                     end else begin
                        rv_in = '0;
                     end
                     i_in     = i_ff + PCW'(1);
                     neg_in   = 1'b0;
                     hit_in   = 1'b0;
                     have_in  = 1'b0;
                     hiph_in  = 1'b0;
                     state_in = S_CL_NEG;
                  end
                  CH_QUEST: begin
                     if (!failed_ff) begin
                        if (ndata == CH_SLASH) failed_in = 1'b1;
                        sp_in = sp_ff + NCW'(1);
                     end
                     i_in = i_ff + PCW'(1);
                  end
                  CH_BSLASH: begin
                     if (({1'b0, i_ff} + (PCW + 1)'(1)) >= {1'b0, ce_ff}) begin
                        fin         = 1'b1;
                        fin_verdict = V_BAD;
                     end else begin
                        i_in     = i_ff + PCW'(1);
                        state_in = S_CM_ESC;
                     end
                  end
                  default: begin
                     if (!failed_ff) begin
                        if (pdata != ndata) failed_in = 1'b1;
                        sp_in = sp_ff + NCW'(1);
                     end
                     i_in = i_ff + PCW'(1);
                  end
               endcase
            end
         end

         S_CM_ESC: begin
            if (!ph_ff) begin
               ph_in = 1'b1;
            end else begin
               ph_in = 1'b0;
               if (!failed_ff) begin
                  if (pdata != ndata) failed_in = 1'b1;
                  sp_in = sp_ff + NCW'(1);
               end
               i_in     = i_ff + PCW'(1);
               state_in = S_CM;
            end
         end

         S_CL_NEG: begin
            if (!ph_ff) begin
               if (i_ff >= ce_ff) state_in = S_CL_BND;
               else               ph_in = 1'b1;
            end else begin
               ph_in = 1'b0;
               if (pdata == CH_CARET) begin
                  neg_in = 1'b1;
                  i_in   = i_ff + PCW'(1);
               end
               state_in = S_CL_BND;
            end
         end

         S_CL_BND: begin
            if (!ph_ff) begin
               if (i_ff >= ce_ff) begin
                  fin         = 1'b1;
                  fin_verdict = V_BAD;
               end else begin
                  ph_in = 1'b1;
               end
            end else begin
               ph_in = 1'b0;
               if (pdata == CH_RBRACK && have_ff && !hiph_ff) begin
                  // class closes
                  i_in = i_ff + PCW'(1);
                  if (hit_ff == neg_ff) failed_in = 1'b1;
                  state_in = S_CM;
               end else if (pdata == CH_DASH || pdata == CH_RBRACK) begin
                  fin         = 1'b1;
                  fin_verdict = V_BAD;
               end else if (({1'b0, i_ff} + (PCW + 1)'(1)) >= {1'b0, ce_ff}) begin
                  fin         = 1'b1;
                  fin_verdict = V_BAD;
               end else if (pdata == CH_BSLASH) begin
                  i_in     = i_ff + PCW'(1);
                  state_in = S_CL_ESC;
               end else begin
                  i_in       = i_ff + PCW'(1);
                  bound_done = 1'b1;
               end
            end
         end

         S_CL_ESC: begin
            if (!ph_ff) begin
               ph_in = 1'b1;
            end else begin
               ph_in = 1'b0;
               if (({1'b0, i_ff} + (PCW + 1)'(1)) >= {1'b0, ce_ff}) begin
                  fin         = 1'b1;
                  fin_verdict = V_BAD;
               end else begin
                  i_in       = i_ff + PCW'(1);
                  bound_done = 1'b1;
               end
            end
         end

         S_CL_DASH: begin
            if (!ph_ff) begin
               ph_in = 1'b1;
            end else begin
               ph_in = 1'b0;
               if (pdata == CH_DASH) begin
                  i_in     = i_ff + PCW'(1);
                  hiph_in  = 1'b1;
               end else begin
                  if (lo_ff == rv_ff) hit_in = 1'b1;
                  have_in = 1'b1;
               end
               state_in = S_CL_BND;
            end
         end

         S_RESULT: begin
            case (mode_ff)
               M_MAIN: begin
                  if (!failed_ff && (sp_ff == nc_ff || ce_ff < pc_ff)) begin
                     np_in    = sp_ff;
                     pp_in    = ce_ff;
                     state_in = S_MAIN;
                  end else if (star_ff) begin
                     n_in     = np_ff;
                     mode_in  = M_RETRY;
                     state_in = S_RETRY;
                  end else begin
                     pp_in    = ce_ff;
                     mode_in  = M_DRAIN;
                     state_in = S_MAIN;
                  end
               end
               M_RETRY: begin
                  if (!failed_ff && !(ce_ff >= pc_ff && sp_ff < nc_ff)) begin
                     np_in    = sp_ff;
                     pp_in    = ce_ff;
                     mode_in  = M_MAIN;
                     state_in = S_MAIN;
                  end else begin
                     n_in     = n_ff + NCW'(1);
                     state_in = S_RETRY;
                  end
               end
               default: begin
                  pp_in    = ce_ff;
                  state_in = S_MAIN;
               end
            endcase
         end

         S_RETRY: begin
            if (!ph_ff) begin
               if (n_ff >= nc_ff) begin
                  pp_in    = ce_ff;
                  mode_in  = M_DRAIN;
                  state_in = S_MAIN;
               end else begin
                  ph_in = 1'b1;
               end
            end else begin
               ph_in = 1'b0;
               if (ndata == CH_SLASH) begin
                  pp_in    = ce_ff;
                  mode_in  = M_DRAIN;
                  state_in = S_MAIN;
               end else begin
                  i_in      = cs_ff;
                  sp_in     = n_ff + NCW'(1);
                  failed_in = 1'b0;
                  state_in  = S_CM;
               end
            end
         end

         default: state_in = S_IDLE;
      endcase

      // a class bound is in hand: low bound waits for a dash, high bound closes a range
      if (bound_done) begin
         if (!hiph_ff) begin
            lo_in    = bound;
            state_in = S_CL_DASH;
         end else begin
            if (lo_ff <= rv_ff && rv_ff <= bound) hit_in = 1'b1;
            have_in  = 1'b1;
            hiph_in  = 1'b0;
            state_in = S_CL_BND;
         end
      end

      // verdict beat, stores emptied
      if (fin) begin
         rsp_valid_in   = 1'b1;
         rsp_verdict_in = fin_verdict;
         pc_in          = '0;
         nc_in          = '0;
         ovf_in         = 1'b0;
         ph_in          = 1'b0;
         state_in       = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= M_MAIN;
         ph_ff        <= 1'b0;
         pc_ff        <= '0;
         nc_ff        <= '0;
         ovf_ff       <= 1'b0;
         pp_ff        <= '0;
         q_ff         <= '0;
         cs_ff        <= '0;
         ce_ff        <= '0;
         i_ff         <= '0;
         np_ff        <= '0;
         sp_ff        <= '0;
         n_ff         <= '0;
         failed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         ph_ff        <= ph_in;
         pc_ff        <= pc_in;
         nc_ff        <= nc_in;
         ovf_ff       <= ovf_in;
         pp_ff        <= pp_in;
         q_ff         <= q_in;
         cs_ff        <= cs_in;
         ce_ff        <= ce_in;
         i_ff         <= i_in;
         np_ff        <= np_in;
         sp_ff        <= sp_in;
         n_ff         <= n_in;
         failed_ff    <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      star_ff        <= star_in;
      incls_ff       <= incls_in;
      neg_ff         <= neg_in;
      hit_ff         <= hit_in;
      have_ff        <= have_in;
      hiph_ff        <= hiph_in;
      rv_ff          <= rv_in;
      lo_ff          <= lo_in;
      rsp_verdict_ff <= rsp_verdict_in;
   end

`ifndef SYNTHESIS
   // a verdict beat always comes with both stores emptied
   a_cleared_on_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (pc_ff == '0 && nc_ff == '0 && !ovf_ff))
      else $error("stores not cleared with verdict");

   // a walk never runs with an overflow pending
   a_no_walk_on_overflow: assert property (@(posedge clock) disable iff (reset)
      busy |-> !ovf_ff)
      else $error("walk started with overflow pending");

   // chunk match reads stay inside the chunk
   a_cm_in_chunk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CM && ph_ff) |-> (i_ff < ce_ff && ce_ff <= pc_ff))
      else $error("chunk match read outside chunk");

   // load counts never pass capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (pc_ff <= PCW'(PATTERN_DEPTH) && nc_ff <= NCW'(NAME_DEPTH)))
      else $error("fill count past capacity");
`endif

endmodule
`default_nettype wire
